### hw/rtl/isp_pkg.sv
`timescale 1ns / 1ps
// isp_pkg: shared types, constants and fixed-point helpers for the per-axis integrator
// used by isp_cfg, isp_mul, integration_step_per_axis and isp_checker; depends on nothing

package isp_pkg;

	// fixed-point format of every data field
	localparam int DATA_WIDTH        = 32;
	localparam int DEF_FRACTION_BITS = 16;
	localparam int PROD_WIDTH        = 2 * DATA_WIDTH;

	// configuration registers
	localparam int STEP_WIDTH      = 31;
	localparam int METHOD_WIDTH    = 2;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [STEP_WIDTH-1:0] RESET_TIME_STEP    = STEP_WIDTH'(65536);
	localparam logic [STEP_WIDTH-1:0] RESET_INVERSE_STEP = STEP_WIDTH'(65536);

	localparam logic signed [DATA_WIDTH-1:0] FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// integration rule; the unused code runs as leapfrog
	typedef enum logic [METHOD_WIDTH-1:0] {
		METHOD_EULER    = 2'd0,
		METHOD_VERLET   = 2'd1,
		METHOD_LEAPFROG = 2'd2
	} method_t;

	// register indexes on the configuration channel
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_METHOD       = 2'd0,
		REG_TIME_STEP    = 2'd1,
		REG_INVERSE_STEP = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] current_position;
		logic signed [DATA_WIDTH-1:0] earlier_position;
		logic signed [DATA_WIDTH-1:0] velocity;
		logic signed [DATA_WIDTH-1:0] accel_now;
		logic signed [DATA_WIDTH-1:0] accel_before;
		logic                         active;
	} isp_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] new_position;
		logic signed [DATA_WIDTH-1:0] new_velocity;
		logic signed [DATA_WIDTH-1:0] next_earlier_position;
	} isp_out_t;

	// register file contents as seen by the datapath
	typedef struct packed {
		method_t                      method;
		logic [STEP_WIDTH-1:0]        time_step;
		logic [STEP_WIDTH-1:0]        inverse_step;
		logic signed [DATA_WIDTH-1:0] step_sq;
	} isp_cfg_t;

	// floor shift of a full product by the fraction bits, then clamp to the data width
	function automatic logic signed [DATA_WIDTH-1:0] scale_sat(
		input logic signed [PROD_WIDTH-1:0] prod,
		input int unsigned                  frac
	);
		logic signed [PROD_WIDTH-1:0]      sh;
		logic [PROD_WIDTH-DATA_WIDTH:0]    upper;
		sh    = prod >>> frac;
		upper = sh[PROD_WIDTH-1:DATA_WIDTH-1];
		if ((&upper) || (~|upper)) begin
			scale_sat = sh[DATA_WIDTH-1:0];
		end else if (sh[PROD_WIDTH-1]) begin
			scale_sat = FX_MIN;
		end else begin
			scale_sat = FX_MAX;
		end
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_add(
		input logic signed [DATA_WIDTH-1:0] x,
		input logic signed [DATA_WIDTH-1:0] y
	);
		logic [DATA_WIDTH:0] s;
		s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			sat_add = s[DATA_WIDTH] ? FX_MIN : FX_MAX;
		end else begin
			sat_add = s[DATA_WIDTH-1:0];
		end
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
		input logic signed [DATA_WIDTH-1:0] x,
		input logic signed [DATA_WIDTH-1:0] y
	);
		logic [DATA_WIDTH:0] s;
		s = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
			sat_sub = s[DATA_WIDTH] ? FX_MIN : FX_MAX;
		end else begin
			sat_sub = s[DATA_WIDTH-1:0];
		end
	endfunction

endpackage

### hw/rtl/isp_cfg.sv
`timescale 1ns / 1ps
// isp_cfg: configuration register file with the precomputed squared time step
// depends on isp_pkg

module isp_cfg import isp_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [STEP_WIDTH-1:0]      cfg_data,
	output isp_cfg_t                   regs
);

	localparam logic signed [PROD_WIDTH-1:0] RESET_SQ =
		PROD_WIDTH'(RESET_TIME_STEP) * PROD_WIDTH'(RESET_TIME_STEP);

	method_t                      method_q;
	logic [STEP_WIDTH-1:0]        time_step_q;
	logic [STEP_WIDTH-1:0]        inverse_step_q;
	logic signed [DATA_WIDTH-1:0] step_sq_q;
	logic signed [PROD_WIDTH-1:0] data_sq;

	assign cfg_ready = 1'b1;
	assign data_sq   = PROD_WIDTH'(cfg_data) * PROD_WIDTH'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q       <= METHOD_EULER;
			time_step_q    <= RESET_TIME_STEP;
			inverse_step_q <= RESET_INVERSE_STEP;
			step_sq_q      <= scale_sat(RESET_SQ, FRACTION_BITS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_METHOD: begin
					method_q <= method_t'(cfg_data[METHOD_WIDTH-1:0]);
				end
				REG_TIME_STEP: begin
					time_step_q <= cfg_data;
					step_sq_q   <= scale_sat(data_sq, FRACTION_BITS);
				end
				REG_INVERSE_STEP: begin
					inverse_step_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign regs.method       = method_q;
	assign regs.time_step    = time_step_q;
	assign regs.inverse_step = inverse_step_q;
	assign regs.step_sq      = step_sq_q;

endmodule

### hw/rtl/isp_mul.sv
`timescale 1ns / 1ps
// isp_mul: two-stage fixed-point multiplier, product register then scaled and clamped result
// depends on isp_pkg

module isp_mul import isp_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                         clk,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] y
);

	logic signed [PROD_WIDTH-1:0] prod_s1;
	logic signed [DATA_WIDTH-1:0] y_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_WIDTH'(a) * PROD_WIDTH'(b);
		y_s2    <= scale_sat(prod_s1, FRACTION_BITS);
	end

	assign y = y_s2;

endmodule

### hw/rtl/integration_step_per_axis.sv
`timescale 1ns / 1ps
// integration_step_per_axis: one-axis particle integrator (euler, verlet, leapfrog)
// depends on isp_pkg, isp_cfg, isp_mul
//
//   channel  | ports                                    | transaction
//   ---------+------------------------------------------+-------------------------------
//   command  | start, busy, cmd                         | start high while busy low
//   result   | done, result                             | done high, one cycle, no stall
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid and cfg_ready high
//
// one command per cycle; a taken command passes through stages s1 to s5 and then the done register
// the pipeline is two multiplier passes in series, each two register stages deep, with a saturating
// subtract alongside the first pass and a saturating add stage between them and after them
// busy stays low: there is no shared unit and the receiver takes every result
// reset clears the valid bits and loads the default registers; no clearing pass
// config writes are meant for an empty pipeline

module integration_step_per_axis import isp_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  isp_in_t                    cmd,
	output logic                       done,
	output isp_out_t                   result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [STEP_WIDTH-1:0]      cfg_data
);

	// per-item values carried alongside the multipliers
	typedef struct packed {
		method_t                      method;
		logic                         active;
		logic signed [DATA_WIDTH-1:0] pos;
		logic signed [DATA_WIDTH-1:0] prev;
		logic signed [DATA_WIDTH-1:0] vel;
		logic signed [DATA_WIDTH-1:0] diff;   // saturated p - p_prev
	} meta_t;

	// results of the middle add stage
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] v1;     // v + a*dt or v + a_prev*dt/2
		logic signed [DATA_WIDTH-1:0] sum;    // p + diff, verlet only
		logic signed [DATA_WIDTH-1:0] m3;     // a*dt/2 or a*dt^2
	} mid_t;

	isp_cfg_t regs;

	logic accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic done_q;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	mid_t  mid_s3, mid_s4, mid_s5;
	isp_out_t result_q;

	logic signed [DATA_WIDTH-1:0] dt_c, half_c, inv_c;
	logic in_leap, in_verlet, s3_verlet;
	logic signed [DATA_WIDTH-1:0] mul_a_a, mul_a_b, mul_a_y;
	logic signed [DATA_WIDTH-1:0] mul_c_b, mul_c_y;
	logic signed [DATA_WIDTH-1:0] mul_b_a, mul_b_b, mul_b_y;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	isp_cfg #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.regs     (regs)
	);

	// step coefficients as signed operands; dt/2 floors
	assign dt_c   = signed'(DATA_WIDTH'(regs.time_step));
	assign half_c = signed'(DATA_WIDTH'(regs.time_step >> 1));
	assign inv_c  = signed'(DATA_WIDTH'(regs.inverse_step));

	// anything other than euler or verlet runs as leapfrog
	assign in_verlet = (regs.method == METHOD_VERLET);
	assign in_leap   = (regs.method != METHOD_EULER) && !in_verlet;
	assign s3_verlet = (meta_s3.method == METHOD_VERLET);

	// first pass: velocity kick (euler a*dt, leapfrog a_prev*dt/2)
	assign mul_a_a = in_leap ? cmd.accel_before : cmd.accel_now;
	assign mul_a_b = in_leap ? half_c : dt_c;

	// first pass, second lane: closing kick a*dt/2 or verlet a*dt^2
	assign mul_c_b = in_verlet ? regs.step_sq : half_c;

	isp_mul #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mul_a (
		.clk(clk),
		.a  (mul_a_a),
		.b  (mul_a_b),
		.y  (mul_a_y)
	);

	isp_mul #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mul_c (
		.clk(clk),
		.a  (cmd.accel_now),
		.b  (mul_c_b),
		.y  (mul_c_y)
	);

	// second pass: drift v1*dt, or verlet velocity diff*inv_dt
	assign mul_b_a = s3_verlet ? meta_s3.diff : mid_s3.v1;
	assign mul_b_b = s3_verlet ? inv_c : dt_c;

	isp_mul #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mul_b (
		.clk(clk),
		.a  (mul_b_a),
		.b  (mul_b_b),
		.y  (mul_b_y)
	);

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done_q <= vld_s5;
		end
	end

	// payload stages, in step with the multiplier registers
	always_ff @(posedge clk) begin
		// stage 1: capture, position difference, first products
		meta_s1.method <= regs.method;
		meta_s1.active <= cmd.active;
		meta_s1.pos    <= cmd.current_position;
		meta_s1.prev   <= cmd.earlier_position;
		meta_s1.vel    <= cmd.velocity;
		meta_s1.diff   <= sat_sub(cmd.current_position, cmd.earlier_position);

		// stage 2: first products scaled
		meta_s2 <= meta_s1;

		// stage 3: kicked velocity and verlet position sum
		meta_s3    <= meta_s2;
		mid_s3.v1  <= sat_add(meta_s2.vel, mul_a_y);
		mid_s3.sum <= sat_add(meta_s2.pos, meta_s2.diff);
		mid_s3.m3  <= mul_c_y;

		// stages 4 and 5: second product
		meta_s4 <= meta_s3;
		mid_s4  <= mid_s3;
		meta_s5 <= meta_s4;
		mid_s5  <= mid_s4;

		// output register: final adds and the inactive bypass
		if (!meta_s5.active) begin
			result_q.new_position          <= meta_s5.pos;
			result_q.new_velocity          <= meta_s5.vel;
			result_q.next_earlier_position <= meta_s5.prev;
		end else begin
			result_q.next_earlier_position <= meta_s5.pos;
			case (meta_s5.method)
				METHOD_EULER: begin
					result_q.new_position <= sat_add(meta_s5.pos, mul_b_y);
					result_q.new_velocity <= mid_s5.v1;
				end
				METHOD_VERLET: begin
					result_q.new_position <= sat_add(mid_s5.sum, mid_s5.m3);
					result_q.new_velocity <= mul_b_y;
				end
				default: begin
					result_q.new_position <= sat_add(meta_s5.pos, mul_b_y);
					result_q.new_velocity <= sat_add(mid_s5.v1, mid_s5.m3);
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hw/rtl/isp_checker.sv
`timescale 1ns / 1ps
// isp_port_props: port-level assertions for the per-axis integrator, bound to the top level
// depends on isp_pkg and integration_step_per_axis

module isp_port_props import isp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input isp_in_t  cmd,
	input logic     done,
	input isp_out_t result
);

	localparam int LATENCY = 6;

	// every taken command gives its result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("taken command produced no result");

	// no result without a command taken the same latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a command");

	// the next earlier position is the old position, or passes through when inactive
	a_earlier_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.next_earlier_position ==
			($past(cmd.active, LATENCY) ? $past(cmd.current_position, LATENCY)
			                            : $past(cmd.earlier_position, LATENCY))))
		else $error("next earlier position mismatch");

	// an inactive item keeps its position and velocity
	a_inactive_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(cmd.active, LATENCY)) |->
			(result.new_position == $past(cmd.current_position, LATENCY) &&
			 result.new_velocity == $past(cmd.velocity, LATENCY)))
		else $error("inactive item was modified");

endmodule

bind integration_step_per_axis isp_port_props u_isp_port_props (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.result(result)
);

### tb/isp_checker.sv
`timescale 1ns / 1ps
// isp_checker: watches the command, result and config channels of the per-axis integrator,
// predicts every result and compares it; depends on isp_pkg only

module isp_checker import isp_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  isp_in_t                    cmd,
	input  logic                       done,
	input  isp_out_t                   result,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [STEP_WIDTH-1:0]      cfg_data,
	output int                         mismatches,
	output int                         pending
);

	logic [METHOD_WIDTH-1:0] rule_q;
	logic [STEP_WIDTH-1:0]   step_q;
	logic [STEP_WIDTH-1:0]   inv_step_q;
	isp_out_t                expected_axis_q[$];

	function automatic logic signed [DATA_WIDTH-1:0] clamp_fx(input longint x);
		if (x > longint'(FX_MAX)) begin
			return FX_MAX;
		end else if (x < longint'(FX_MIN)) begin
			return FX_MIN;
		end
		return DATA_WIDTH'(x);
	endfunction

	// exact product, floor shift, then clamp
	function automatic logic signed [DATA_WIDTH-1:0] mul_fx(input longint x, input longint y);
		longint prod;
		prod = (x * y) >>> FRACTION_BITS;
		return clamp_fx(prod);
	endfunction

	function automatic isp_out_t predict_axis(input isp_in_t c);
		isp_out_t r;
		longint   p, pp, v, a, ap, dt, inv, d, v1, h;
		p   = longint'($signed(c.current_position));
		pp  = longint'($signed(c.earlier_position));
		v   = longint'($signed(c.velocity));
		a   = longint'($signed(c.accel_now));
		ap  = longint'($signed(c.accel_before));
		dt  = longint'(step_q);
		inv = longint'(inv_step_q);
		r.new_position          = c.current_position;
		r.new_velocity          = c.velocity;
		r.next_earlier_position = c.earlier_position;
		if (c.active) begin
			r.next_earlier_position = c.current_position;
			case (rule_q)
				METHOD_EULER: begin
					v1 = clamp_fx(v + mul_fx(a, dt));
					r.new_velocity = DATA_WIDTH'(v1);
					r.new_position = clamp_fx(p + mul_fx(v1, dt));
				end
				METHOD_VERLET: begin
					d = clamp_fx(p - pp);
					r.new_velocity = mul_fx(d, inv);
					r.new_position = clamp_fx(longint'(clamp_fx(p + d))
						+ longint'(mul_fx(a, mul_fx(dt, dt))));
				end
				default: begin
					// leapfrog, also for the spare code
					h  = dt >> 1;
					v1 = clamp_fx(v + mul_fx(ap, h));
					r.new_position = clamp_fx(p + mul_fx(v1, dt));
					r.new_velocity = clamp_fx(v1 + mul_fx(a, h));
				end
			endcase
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [DATA_WIDTH-1:0] want,
			input logic signed [DATA_WIDTH-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		isp_out_t want;
		if (!arst_n) begin
			rule_q     = METHOD_EULER;
			step_q     = RESET_TIME_STEP;
			inv_step_q = RESET_INVERSE_STEP;
			expected_axis_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (done) begin
				if (expected_axis_q.size() == 0) begin
					$error("result with no transaction outstanding: %h", result);
					mismatches++;
				end else begin
					want = expected_axis_q.pop_front();
					check_field("new_position", want.new_position, result.new_position);
					check_field("new_velocity", want.new_velocity, result.new_velocity);
					check_field("next_earlier_position", want.next_earlier_position,
						result.next_earlier_position);
				end
			end
			if (start && !busy) begin
				expected_axis_q.push_back(predict_axis(cmd));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_METHOD:       rule_q     = cfg_data[METHOD_WIDTH-1:0];
					REG_TIME_STEP:    step_q     = cfg_data;
					REG_INVERSE_STEP: inv_step_q = cfg_data;
					default: ;
				endcase
			end
			pending = expected_axis_q.size();
		end
	end

endmodule

### tb/tb_integration_step_per_axis.sv
`timescale 1ns / 1ps
// tb_integration_step_per_axis: stimulus and verdict for the per-axis integrator
// depends on isp_pkg, integration_step_per_axis and isp_checker

module tb_integration_step_per_axis;
	import isp_pkg::*;

	// spare selector code and unmapped register index, both legal on the ports
	localparam logic [METHOD_WIDTH-1:0]    METHOD_SPARE = 2'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED   = 2'd3;

	localparam logic [STEP_WIDTH-1:0] STEP_MAX  = {STEP_WIDTH{1'b1}};
	localparam logic [STEP_WIDTH-1:0] STEP_ONE  = STEP_WIDTH'(65536);

	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 104;
	localparam int MAX_GAP      = 40;
	// pipeline is six deep; leave a margin after the last result
	localparam int DRAIN_CYCLES = 16;
	// longest legal quiet stretch is a sender gap or the pipeline fill
	localparam int QUIET_LIMIT  = 2000;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	isp_in_t                    cmd;
	logic                       done;
	isp_out_t                   result;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [STEP_WIDTH-1:0]      cfg_data;

	int mismatch_count;
	int pending_count;
	int quiet_cycles;
	int idle_pct;
	int burst_left;

	integration_step_per_axis #(
		.FRACTION_BITS(DEF_FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	isp_checker #(
		.FRACTION_BITS(DEF_FRACTION_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatch_count),
		.pending(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any transaction on any channel clears the quiet count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// mix of full-range words, small q16.16 values and the two extremes
	function automatic logic signed [DATA_WIDTH-1:0] rand_fx();
		case ($urandom_range(9))
			0:       return FX_MAX;
			1:       return FX_MIN;
			2:       return DATA_WIDTH'($signed($urandom_range(0, 64)) - 32);
			3, 4, 5: return DATA_WIDTH'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return DATA_WIDTH'($urandom());
		endcase
	endfunction

	function automatic isp_in_t rand_axis_item();
		isp_in_t c;
		c.current_position = rand_fx();
		// verlet cares about the gap between the two positions, so keep it small often
		if ($urandom_range(2) == 0) begin
			c.earlier_position = rand_fx();
		end else begin
			c.earlier_position = c.current_position
				+ DATA_WIDTH'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		end
		c.velocity     = rand_fx();
		c.accel_now    = rand_fx();
		c.accel_before = rand_fx();
		c.active       = ($urandom_range(7) != 0);
		return c;
	endfunction

	function automatic isp_in_t make_item(input logic signed [DATA_WIDTH-1:0] p,
			input logic signed [DATA_WIDTH-1:0] pp, input logic signed [DATA_WIDTH-1:0] v,
			input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] ap,
			input logic act);
		isp_in_t c;
		c.current_position = p;
		c.earlier_position = pp;
		c.velocity         = v;
		c.accel_now        = a;
		c.accel_before     = ap;
		c.active           = act;
		return c;
	endfunction

	// sender gap drawn per cycle at the phase's idle rate, with idle-free bursts
	function automatic int draw_gap();
		int n;
		n = 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(31) == 0) begin
			burst_left = $urandom_range(4, 16);
		end
		while (n < MAX_GAP && $urandom_range(99) < idle_pct) begin
			n++;
		end
		return n;
	endfunction

	// one command transaction; start stays high into the next one when no gap falls
	task automatic send_axis(input isp_in_t item);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// one register transaction; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [STEP_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// upper bits of the method word are don't-care, so fill them at random when junk_upper is set
	task automatic configure(input logic [METHOD_WIDTH-1:0] rule,
			input logic [STEP_WIDTH-1:0] dt, input logic [STEP_WIDTH-1:0] inv,
			input logic junk_upper);
		logic [STEP_WIDTH-1:0] word;
		word = junk_upper ? STEP_WIDTH'($urandom()) : '0;
		word[METHOD_WIDTH-1:0] = rule;
		write_reg(REG_METHOD, word);
		write_reg(REG_TIME_STEP, dt);
		write_reg(REG_INVERSE_STEP, inv);
		cfg_valid <= 1'b0;
	endtask

	// stop issuing and let the pipeline empty so registers can change safely
	task automatic drain();
		start <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	initial begin
		logic [METHOD_WIDTH-1:0] rule;
		logic [STEP_WIDTH-1:0]   dt;
		logic [STEP_WIDTH-1:0]   inv;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		idle_pct   = 0;
		burst_left = 0;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part: every rule, the spare code, extremes, saturation and pass-through
		for (int m = 0; m < 4; m++) begin
			case (m)
				0:       configure(METHOD_EULER, STEP_ONE, STEP_ONE, 1'b0);
				1:       configure(METHOD_VERLET, STEP_WIDTH'(655), STEP_WIDTH'(6553600), 1'b0);
				2:       configure(METHOD_LEAPFROG, STEP_MAX, STEP_MAX, 1'b0);
				default: configure(METHOD_SPARE, STEP_WIDTH'(32768), STEP_WIDTH'(131072), 1'b0);
			endcase
			send_axis(make_item('0, '0, '0, '0, '0, 1'b1));
			send_axis(make_item(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b1));
			send_axis(make_item(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1));
			// opposite extremes drive the position difference into saturation
			send_axis(make_item(FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, 1'b1));
			// inactive item passes through untouched
			send_axis(make_item(FX_MAX, FX_MIN, 32'sd1, -32'sd1, FX_MAX, 1'b0));
			// ordinary values: p 1.5, pp 1.25, v -0.5, a 2.0, ap -3.0
			send_axis(make_item(32'sh0001_8000, 32'sh0001_4000, -32'sh0000_8000,
				32'sh0002_0000, -32'sh0003_0000, 1'b1));
			drain();
		end

		// random part: each phase holds one register setting and one idle rate
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0:       idle_pct = 0;
				1:       idle_pct = 82;
				2:       idle_pct = 0;
				default: idle_pct = 20;
			endcase
			case (ph)
				0:  begin rule = METHOD_EULER;    dt = STEP_ONE;            inv = STEP_ONE; end
				1:  begin rule = METHOD_VERLET;   dt = STEP_WIDTH'(655);    inv = STEP_WIDTH'(6553600); end
				2:  begin rule = METHOD_LEAPFROG; dt = STEP_WIDTH'(32768);  inv = STEP_WIDTH'(131072); end
				3:  begin rule = METHOD_SPARE;    dt = STEP_ONE;            inv = STEP_ONE; end
				4:  begin rule = METHOD_EULER;    dt = STEP_MAX;            inv = STEP_WIDTH'(1); end
				5:  begin rule = METHOD_VERLET;   dt = STEP_WIDTH'(1);      inv = STEP_MAX; end
				6:  begin rule = METHOD_LEAPFROG; dt = STEP_MAX;            inv = STEP_MAX; end
				// zero steps are accepted and null every product
				7:  begin rule = METHOD_EULER;    dt = '0;                  inv = '0; end
				8:  begin rule = METHOD_VERLET;   dt = STEP_WIDTH'($urandom()); inv = STEP_WIDTH'($urandom()); end
				9:  begin rule = METHOD_LEAPFROG; dt = STEP_WIDTH'(1);      inv = STEP_WIDTH'(1); end
				10: begin rule = METHOD_WIDTH'($urandom_range(3));
					dt = STEP_WIDTH'($urandom()); inv = STEP_WIDTH'($urandom()); end
				default: begin rule = METHOD_LEAPFROG;
					dt = STEP_WIDTH'($urandom_range(1, 1 << 20)); inv = STEP_WIDTH'($urandom()); end
			endcase
			if (ph == 0) begin
				// the unmapped index must leave every register alone
				write_reg(REG_UNUSED, STEP_WIDTH'($urandom()));
			end
			configure(rule, dt, inv, 1'b1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_axis(rand_axis_item());
			end
			drain();
		end

		// every expectation has been met; watch a little longer for stray results
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### integration_step_per_axis.f
hw/rtl/isp_pkg.sv
hw/rtl/isp_cfg.sv
hw/rtl/isp_mul.sv
hw/rtl/integration_step_per_axis.sv
hw/rtl/isp_checker.sv
tb/isp_checker.sv
tb/tb_integration_step_per_axis.sv
